### sv/pfr_pkg.sv
// shared constants and types for the position frame receiver
`default_nettype none

package pfr_pkg;

  localparam logic [7:0] HEAD_BYTE = 8'h7B;
  localparam logic [7:0] TAIL_BYTE = 8'h7D;

  // frame layout: head, xH, xL, yH, yL, yawH, yawL, bcc, tail
  localparam int unsigned TAIL_INDEX  = 8;
  localparam int unsigned BCC_INDEX   = 7;
  localparam int unsigned STORE_DEPTH = 8;
  localparam int unsigned STORE_IDX_W = $clog2(STORE_DEPTH);

  localparam int unsigned COUNT_W           = 6;
  localparam int unsigned COLLECT_LIMIT_DEF = 47;

  typedef enum logic [1:0] {
    STATUS_GOOD      = 2'd0,
    STATUS_MISPLACED = 2'd1,
    STATUS_BCC_ERROR = 2'd2
  } status_t;

  typedef struct packed {
    status_t            status;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic signed [15:0] yaw_pos;
  } result_t;

  // what the parser reports for the word it is looking at
  typedef struct packed {
    logic    valid;
    result_t result;
  } event_t;

endpackage

`default_nettype wire

### sv/pfr_if.sv
// valid/ready channel interfaces for received bytes and frame results
`default_nettype none

interface pfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pfr_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [15:0] x_pos;
  logic signed [15:0] y_pos;
  logic signed [15:0] yaw_pos;

  modport source (output valid, output status, output x_pos, output y_pos,
                  output yaw_pos, input ready);
  modport sink   (input valid, input status, input x_pos, input y_pos,
                  input yaw_pos, output ready);
endinterface

`default_nettype wire

### sv/pfr_parse.sv
// frame parser: hunt/collect state, running xor, byte store and last good position
`default_nettype none

module pfr_parse
  import pfr_pkg::*;
#(
  parameter int unsigned COLLECT_LIMIT = COLLECT_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output event_t     evt
);

  logic                     collecting;
  logic [COUNT_W-1:0]       byte_count;
  logic [7:0]               running_xor;
  logic [7:0]               frame_store [STORE_DEPTH];
  logic signed [15:0]       good_x;
  logic signed [15:0]       good_y;
  logic signed [15:0]       good_yaw;

  logic                     limit_hit;
  logic                     active;
  logic                     is_head;
  logic                     is_tail;
  logic                     at_tail_idx;
  logic                     bcc_ok;
  logic                     frame_good;
  logic signed [15:0]       new_x;
  logic signed [15:0]       new_y;
  logic signed [15:0]       new_yaw;

  assign limit_hit   = collecting && (byte_count >= COUNT_W'(COLLECT_LIMIT));
  assign active      = collecting && !limit_hit;
  assign is_head     = (rx_byte == HEAD_BYTE);
  assign is_tail     = (rx_byte == TAIL_BYTE);
  assign at_tail_idx = (byte_count == COUNT_W'(TAIL_INDEX));
  assign bcc_ok      = (running_xor == frame_store[BCC_INDEX]);
  assign frame_good  = active && is_tail && at_tail_idx && bcc_ok;

  // big-endian fields
  assign new_x   = {frame_store[1], frame_store[2]};
  assign new_y   = {frame_store[3], frame_store[4]};
  assign new_yaw = {frame_store[5], frame_store[6]};

  always_comb begin
    evt.valid = active && is_tail;
    priority if (!at_tail_idx) begin
      evt.result.status = STATUS_MISPLACED;
    end else if (!bcc_ok) begin
      evt.result.status = STATUS_BCC_ERROR;
    end else begin
      evt.result.status = STATUS_GOOD;
    end
    evt.result.x_pos   = frame_good ? new_x   : good_x;
    evt.result.y_pos   = frame_good ? new_y   : good_y;
    evt.result.yaw_pos = frame_good ? new_yaw : good_yaw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting  <= 1'b0;
      byte_count  <= '0;
      running_xor <= '0;
      good_x      <= '0;
      good_y      <= '0;
      good_yaw    <= '0;
    end else if (step) begin
      if (!active) begin
        // hunting, or just dropped out past the limit
        if (is_head) begin
          collecting  <= 1'b1;
          byte_count  <= COUNT_W'(1);
          running_xor <= HEAD_BYTE;
        end else begin
          collecting  <= 1'b0;
          byte_count  <= '0;
          running_xor <= '0;
        end
      end else if (is_tail) begin
        collecting  <= 1'b0;
        byte_count  <= '0;
        running_xor <= '0;
        if (frame_good) begin
          good_x   <= new_x;
          good_y   <= new_y;
          good_yaw <= new_yaw;
        end
      end else begin
        byte_count <= byte_count + COUNT_W'(1);
        if (byte_count < COUNT_W'(BCC_INDEX)) begin
          running_xor <= running_xor ^ rx_byte;
        end
      end
    end
  end

  // store holds bytes 0..7, no reset
  always_ff @(posedge clk) begin
    if (step) begin
      if (!active && is_head) begin
        frame_store[0] <= HEAD_BYTE;
      end else if (active && (byte_count < COUNT_W'(STORE_DEPTH))) begin
        frame_store[byte_count[STORE_IDX_W-1:0]] <= rx_byte;
      end
    end
  end

endmodule

`default_nettype wire

### sv/position_frame_receiver.sv
// top level of the position frame receiver: input register, parser, result register
`default_nettype none

// position_frame_receiver takes one received byte per word on rx and parses
// nine-byte position frames: head 0x7B, x, y and yaw as big-endian signed
// 16-bit values, an xor check byte over bytes 0..6, and tail 0x7D. every tail
// seen while collecting yields exactly one word on pos: status 0 for a good
// frame, 1 for a tail that is not the ninth byte, 2 for a check byte
// mismatch, always with the last good position (zero until the first good
// frame). a head byte inside a frame is plain data; a frame that grows past
// COLLECT_LIMIT bytes is dropped with no result and the parser hunts again,
// taking that byte as a possible head. rate is one byte per clock,
// sustained while rx is not held off: the counter, running xor and byte
// store all update as a byte leaves the input register, so a
// byte may follow every cycle. a result waiting on pos does not stop
// bytes that produce no result; only a second tail behind an untaken
// result holds rx off.

module position_frame_receiver
  import pfr_pkg::*;
#(
  parameter int unsigned COLLECT_LIMIT = COLLECT_LIMIT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  pfr_in_if.sink           rx,
  pfr_out_if.source        pos
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;

  // result register
  logic       out_valid;
  result_t    out_res;

  event_t     evt;
  logic       out_free;
  logic       process;

  pfr_parse #(
    .COLLECT_LIMIT (COLLECT_LIMIT)
  ) u_parse (
    .clk     (clk),
    .rst     (rst),
    .step    (process),
    .rx_byte (s1_byte),
    .evt     (evt)
  );

  // a held byte moves on unless it makes a result and the result slot is full
  assign out_free = !out_valid || pos.ready;
  assign process  = s1_valid && (!evt.valid || out_free);
  assign rx.ready = !s1_valid || process;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process && evt.valid) begin
      out_valid <= 1'b1;
    end else if (pos.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process && evt.valid) begin
      out_res <= evt.result;
    end
  end

  assign pos.valid   = out_valid;
  assign pos.status  = 2'(out_res.status);
  assign pos.x_pos   = out_res.x_pos;
  assign pos.y_pos   = out_res.y_pos;
  assign pos.yaw_pos = out_res.yaw_pos;

`ifndef SYNTHESIS
  // a held byte that cannot move stays put
  a_hold_byte: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !process |=> s1_valid && $stable(s1_byte))
    else $error("held input byte lost or changed");

  // a new result is only loaded into a free result register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    process && evt.valid |-> out_free)
    else $error("result register overwritten");

  // rx is only held off while a byte waits in the input register
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !rx.ready |-> s1_valid && evt.valid && out_valid && !pos.ready)
    else $error("rx stalled without cause");
`endif

endmodule

`default_nettype wire

### tb/pfr_frame_checker.sv
// frame predictor and result comparison for the position frame receiver bench
`default_nettype none

module pfr_frame_checker
  import pfr_pkg::*;
#(
  parameter int unsigned COLLECT_LIMIT = COLLECT_LIMIT_DEF
) (
  input  logic clk,
  input  logic rst,
  pfr_in_if    rx,
  pfr_out_if   pos,
  output int   errors,
  output int   pending,
  output int   n_good,
  output int   n_misplaced,
  output int   n_bcc_error
);

  // parser shadow state
  logic                     in_frame;
  logic [COUNT_W-1:0]       frame_len;
  logic [7:0]               xor_acc;
  logic [7:0]               frame_bytes [STORE_DEPTH];
  logic signed [15:0]       last_x;
  logic signed [15:0]       last_y;
  logic signed [15:0]       last_yaw;

  result_t expected_frames [$];

  always @(posedge clk) begin : watch
    result_t            want;
    logic [7:0]         rx_word;
    logic [COUNT_W-1:0] idx;
    status_t            verdict;

    if (rst) begin
      in_frame  = 1'b0;
      frame_len = '0;
      xor_acc   = '0;
      last_x    = '0;
      last_y    = '0;
      last_yaw  = '0;
      expected_frames.delete();
    end else begin
      // outgoing word first; nothing accepted on rx this edge can reach pos yet
      if (pos.valid && pos.ready) begin
        if (expected_frames.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: status %0d x %0d y %0d yaw %0d",
                     pos.status, pos.x_pos, pos.y_pos, pos.yaw_pos);
        end else begin
          want = expected_frames.pop_front();
          if (pos.status !== want.status || pos.x_pos !== want.x_pos ||
              pos.y_pos !== want.y_pos || pos.yaw_pos !== want.yaw_pos) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: want status %0d x %0d y %0d yaw %0d, got %0d %0d %0d %0d",
                       want.status, want.x_pos, want.y_pos, want.yaw_pos,
                       pos.status, pos.x_pos, pos.y_pos, pos.yaw_pos);
          end
        end
      end

      if (rx.valid && rx.ready) begin
        rx_word = rx.rx_byte;
        // overlong frame is dropped silently, this word is looked at as a head
        if (in_frame && frame_len >= COLLECT_LIMIT) begin
          in_frame  = 1'b0;
          frame_len = '0;
          xor_acc   = '0;
        end
        if (!in_frame) begin
          if (rx_word == HEAD_BYTE) begin
            in_frame       = 1'b1;
            frame_bytes[0] = HEAD_BYTE;
            frame_len      = COUNT_W'(1);
            xor_acc        = HEAD_BYTE;
          end
        end else begin
          idx = frame_len;
          if (idx < STORE_DEPTH)
            frame_bytes[idx[STORE_IDX_W-1:0]] = rx_word;
          if (idx < BCC_INDEX)
            xor_acc = xor_acc ^ rx_word;
          frame_len = idx + 1'b1;
          if (rx_word == TAIL_BYTE) begin
            if (idx != TAIL_INDEX) begin
              verdict = STATUS_MISPLACED;
              n_misplaced++;
            end else if (xor_acc != frame_bytes[BCC_INDEX]) begin
              verdict = STATUS_BCC_ERROR;
              n_bcc_error++;
            end else begin
              verdict  = STATUS_GOOD;
              last_x   = {frame_bytes[1], frame_bytes[2]};
              last_y   = {frame_bytes[3], frame_bytes[4]};
              last_yaw = {frame_bytes[5], frame_bytes[6]};
              n_good++;
            end
            in_frame     = 1'b0;
            frame_len    = '0;
            xor_acc      = '0;
            want.status  = verdict;
            want.x_pos   = last_x;
            want.y_pos   = last_y;
            want.yaw_pos = last_yaw;
            expected_frames.push_back(want);
          end
        end
      end
    end
    pending = expected_frames.size();
  end

endmodule

`default_nettype wire

### tb/position_frame_receiver_test.sv
// top of the position frame receiver bench: clock, reset, byte stimulus and verdict
`default_nettype none

module position_frame_receiver_test
  import pfr_pkg::*;
;

  localparam int unsigned LIMIT        = COLLECT_LIMIT_DEF;
  localparam int          TARGET_BYTES = 650;
  localparam int          CYCLE_LIMIT  = 200000;
  // slack for the result path and for a late stray word
  localparam int          DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst;

  // clock, period 12
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pfr_in_if  rx_ch ();
  pfr_out_if pos_ch ();

  int errors;
  int pending;
  int n_good;
  int n_misplaced;
  int n_bcc_error;

  position_frame_receiver #(
    .COLLECT_LIMIT (LIMIT)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .pos (pos_ch)
  );

  pfr_frame_checker #(
    .COLLECT_LIMIT (LIMIT)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx_ch),
    .pos         (pos_ch),
    .errors      (errors),
    .pending     (pending),
    .n_good      (n_good),
    .n_misplaced (n_misplaced),
    .n_bcc_error (n_bcc_error)
  );

  // calm marks a stretch where neither side idles
  bit calm;
  int bytes_sent;
  int noise_sent;
  int cycle_count;

  // receiver side: stalls about one cycle in ten unless calm
  always @(posedge clk) begin
    pos_ch.ready <= calm || ($urandom_range(99) >= 10);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL position_frame_receiver");
      $finish;
    end
  end

  // one word on rx, with an occasional idle cycle ahead of it
  task automatic send_byte(input logic [7:0] rx_word);
    if (!calm && $urandom_range(99) < 10) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= rx_word;
    do @(posedge clk); while (rx_ch.ready !== 1'b1);
    bytes_sent++;
  endtask

  // full nine-byte frame; a nonzero bcc_flip corrupts the check byte
  task automatic send_frame(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] yaw, input logic [7:0] bcc_flip);
    logic [7:0] bcc;
    bcc = HEAD_BYTE ^ x[15:8] ^ x[7:0] ^ y[15:8] ^ y[7:0] ^ yaw[15:8] ^ yaw[7:0];
    send_byte(HEAD_BYTE);
    send_byte(x[15:8]);
    send_byte(x[7:0]);
    send_byte(y[15:8]);
    send_byte(y[7:0]);
    send_byte(yaw[15:8]);
    send_byte(yaw[7:0]);
    send_byte(bcc ^ bcc_flip);
    send_byte(TAIL_BYTE);
  endtask

  // head, n random words that are not a tail, then an optional tail
  task automatic send_run(input int n_data, input bit with_tail);
    logic [7:0] data;
    send_byte(HEAD_BYTE);
    repeat (n_data) begin
      do data = 8'($urandom_range(255)); while (data == TAIL_BYTE);
      send_byte(data);
    end
    if (with_tail)
      send_byte(TAIL_BYTE);
  endtask

  initial begin : stimulus
    int         pick;
    logic [7:0] noise;

    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    calm        = 1'b0;
    bytes_sent  = 0;
    noise_sent  = 0;

    rst <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: tail right after head, before any good frame (position reads zero)
    send_byte(HEAD_BYTE);
    send_byte(TAIL_BYTE);
    // extremes of the position, with head bytes as plain data in yaw and bcc
    send_frame(16'h8000, 16'h7FFF, 16'h7B7B, 8'h00);
    // checksum error keeps the last good position
    send_frame(16'hFFFF, 16'h0001, 16'h8000, 8'h80);

    // collect limit: tail as the last word under the limit gives a misplaced tail
    send_run(LIMIT - 2, 1'b1);
    // tail one word later lands after the drop and is ignored
    send_run(LIMIT - 1, 1'b1);
    // full frame with no tail, then a head that arrives exactly at the drop
    send_run(LIMIT - 1, 1'b0);
    send_frame(16'($urandom), 16'($urandom), 16'($urandom), 8'h00);

    // random part: mostly well-formed frames with random contents
    while (bytes_sent - noise_sent < TARGET_BYTES) begin
      calm = (bytes_sent > 250 && bytes_sent < 400);
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_frame(16'($urandom), 16'($urandom), 16'($urandom), 8'h00);
      end else if (pick < 70) begin
        send_frame(16'($urandom), 16'($urandom), 16'($urandom),
                   8'($urandom_range(1, 255)));
      end else if (pick < 80) begin
        // short or long frame ending in a tail
        send_run($urandom_range(0, 12), 1'b1);
      end else if (pick < 85) begin
        // around the collect limit, with or without a tail
        send_run($urandom_range(LIMIT - 4, LIMIT + 6), 1'($urandom_range(1)));
      end else begin
        // noise between frames: no heads, tails allowed
        repeat ($urandom_range(1, 4)) begin
          do noise = 8'($urandom_range(255)); while (noise == HEAD_BYTE);
          send_byte(noise);
          noise_sent++;
        end
      end
    end
    calm = 1'b0;
    rx_ch.valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes (%0d of them noise between frames)", bytes_sent, noise_sent);
    $display("results: %0d good, %0d misplaced tail, %0d checksum error, %0d failures",
             n_good, n_misplaced, n_bcc_error, errors);
    if (errors == 0 && pending == 0)
      $display("PASS position_frame_receiver");
    else
      $display("FAIL position_frame_receiver");
    $finish;
  end

endmodule

`default_nettype wire
